>>> hdl/sha1_pkg.sv
// ============================================================================
// SHA-1 hash core package
// Shared word types, SHA-1 constants, state encodings and round helpers.
// ============================================================================
`default_nettype none

package sha1_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned DIGEST_WORDS = 5;
  localparam int unsigned QUEUE_DEPTH  = 4;

  // Initial chain value (H0 to H4).
  localparam word_t H_INIT [DIGEST_WORDS] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam word_t K_ROUND0 = 32'h5A82_7999;
  localparam word_t K_ROUND1 = 32'h6ED9_EBA1;
  localparam word_t K_ROUND2 = 32'h8F1B_BCDC;
  localparam word_t K_ROUND3 = 32'hCA62_C1D6;

  // Pad marker word and the window slot at which the length words start.
  localparam word_t      PAD_WORD     = 32'h8000_0000;
  localparam logic [3:0] LEN_SLOT     = 4'd14;
  localparam logic [6:0] LAST_ROUND   = 7'd79;
  localparam logic [3:0] LAST_SLOT    = 4'd15;
  localparam logic [2:0] FULL_BYTES   = 3'd4;

  // One beat in the queue between front and back.
  typedef struct packed {
    word_t word;
    logic  final_word;
  } q_word_t;

  typedef enum logic [2:0] {
    FR_DATA,
    FR_PAD80,
    FR_ZERO,
    FR_LEN_HI,
    FR_LEN_LO
  } front_state_e;

  typedef enum logic [1:0] {
    BK_FILL,
    BK_ROUND,
    BK_ADD
  } back_state_e;

  // Keep the valid leading bytes of a short final word and place the pad
  // marker into the first byte that is not valid.
  function automatic word_t pad_final_word(word_t msg, logic [2:0] nbytes);
    word_t res;
    case (nbytes)
      3'd0:    res = 32'h8000_0000;
      3'd1:    res = {msg[31:24], 24'h80_0000};
      3'd2:    res = {msg[31:16], 16'h8000};
      3'd3:    res = {msg[31:8], 8'h80};
      default: res = msg;
    endcase
    return res;
  endfunction

  function automatic word_t round_f(logic [6:0] rnd, word_t b, word_t c, word_t d);
    word_t res;
    case (rnd) inside
      [7'd0:7'd19]:  res = (b & c) | (~b & d);
      [7'd40:7'd59]: res = (b & c) | (b & d) | (c & d);
      default:       res = b ^ c ^ d;
    endcase
    return res;
  endfunction

  function automatic word_t round_k(logic [6:0] rnd);
    word_t res;
    case (rnd) inside
      [7'd0:7'd19]:  res = K_ROUND0;
      [7'd20:7'd39]: res = K_ROUND1;
      [7'd40:7'd59]: res = K_ROUND2;
      default:       res = K_ROUND3;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/sha1_if.sv
// ============================================================================
// SHA-1 stream interfaces
// Valid/ready channels for message beats in and digest beats out.
// ============================================================================
`default_nettype none

interface sha1_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic        last_word;
  logic [2:0]  valid_bytes;

  modport source (output valid, message_word, last_word, valid_bytes, input ready);
  modport sink   (input valid, message_word, last_word, valid_bytes, output ready);
endinterface

interface sha1_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;

  modport source (output valid, digest_word, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

`default_nettype wire

>>> hdl/sha1_front.sv
// ============================================================================
// SHA-1 front end
// Accepts message beats, tracks length and slot, and generates the padding.
// ============================================================================
`default_nettype none

module sha1_front import sha1_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha1_msg_if.sink   msg_i,
  output q_word_t    push_data_o,
  output logic       push_valid_o,
  input  logic       push_ready_i
);

  front_state_e state_q, state_d;
  logic [3:0]   pos_q;
  logic [63:0]  bits_q;
  logic [3:0]   pos_inc;
  logic [2:0]   nbytes;
  logic         in_fire;
  logic         push_fire;
  logic [5:0]   bits_add;

  assign pos_inc   = pos_q + 4'd1;
  assign nbytes    = (msg_i.valid_bytes > FULL_BYTES) ? FULL_BYTES : msg_i.valid_bytes;
  assign in_fire   = msg_i.valid && msg_i.ready;
  assign push_fire = push_valid_o && push_ready_i;
  assign bits_add  = msg_i.last_word ? {nbytes, 3'b000} : 6'd32;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_DATA: begin
        if (in_fire && msg_i.last_word) begin
          if (nbytes == FULL_BYTES) begin
            state_d = FR_PAD80;
          end else if (pos_inc == LEN_SLOT) begin
            state_d = FR_LEN_HI;
          end else begin
            state_d = FR_ZERO;
          end
        end
      end
      FR_PAD80, FR_ZERO: begin
        if (push_ready_i) begin
          state_d = (pos_inc == LEN_SLOT) ? FR_LEN_HI : FR_ZERO;
        end
      end
      FR_LEN_HI: begin
        if (push_ready_i) state_d = FR_LEN_LO;
      end
      FR_LEN_LO: begin
        if (push_ready_i) state_d = FR_DATA;
      end
      default: state_d = FR_DATA;
    endcase
  end

  always_comb begin
    msg_i.ready             = 1'b0;
    push_valid_o            = 1'b1;
    push_data_o.word        = '0;
    push_data_o.final_word  = 1'b0;
    case (state_q)
      FR_DATA: begin
        msg_i.ready      = push_ready_i;
        push_valid_o     = msg_i.valid;
        push_data_o.word = msg_i.last_word ? pad_final_word(msg_i.message_word, nbytes)
                                           : msg_i.message_word;
      end
      FR_PAD80:  push_data_o.word = PAD_WORD;
      FR_ZERO:   push_data_o.word = '0;
      FR_LEN_HI: push_data_o.word = bits_q[63:32];
      FR_LEN_LO: begin
        push_data_o.word       = bits_q[31:0];
        push_data_o.final_word = 1'b1;
      end
      default: push_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_DATA;
      pos_q   <= '0;
      bits_q  <= '0;
    end else begin
      state_q <= state_d;
      if (push_fire) begin
        pos_q <= (state_q == FR_LEN_LO) ? 4'd0 : pos_inc;
      end
      if (in_fire) begin
        bits_q <= bits_q + 64'(bits_add);
      end else if (push_fire && state_q == FR_LEN_LO) begin
        bits_q <= '0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/sha1_fifo.sv
// ============================================================================
// SHA-1 word queue
// Short first-in first-out queue that decouples the front end from the rounds.
// ============================================================================
`default_nettype none

module sha1_fifo import sha1_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_word_t push_data_i,
  input  logic    push_valid_i,
  output logic    push_ready_o,
  output q_word_t pop_data_o,
  output logic    pop_valid_o,
  input  logic    pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_word_t           mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/sha1_back.sv
// ============================================================================
// SHA-1 compression back end
// Fills the schedule window, runs one round per cycle and emits the digest.
// ============================================================================
`default_nettype none

module sha1_back import sha1_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  q_word_t       pop_data_i,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  sha1_digest_if.source digest_o
);

  back_state_e state_q, state_d;
  logic [3:0]  fill_q;
  logic [6:0]  rnd_q;
  logic        final_q;
  logic        out_busy_q;
  logic [2:0]  out_idx_q;
  word_t       chain_q  [DIGEST_WORDS];
  word_t       wv_q     [DIGEST_WORDS];
  word_t       digest_q [DIGEST_WORDS];
  word_t       chain_sum [DIGEST_WORDS];
  word_t       win_q [16];
  word_t       sched_x, sched_new, temp;
  logic        pop_fire, add_go, out_fire, out_done;

  assign pop_fire = pop_valid_i && pop_ready_o;
  assign add_go   = (state_q == BK_ADD) && !(final_q && out_busy_q);
  assign out_fire = digest_o.valid && digest_o.ready;
  assign out_done = out_fire && digest_o.digest_last;

  // The window holds W[t] .. W[t+15]; tap 0 is the word of this round.
  assign sched_x   = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign sched_new = {sched_x[30:0], sched_x[31]};
  assign temp      = {wv_q[0][26:0], wv_q[0][31:27]}
                   + round_f(rnd_q, wv_q[1], wv_q[2], wv_q[3])
                   + wv_q[4] + win_q[0] + round_k(rnd_q);

  always_comb begin
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      chain_sum[i] = chain_q[i] + wv_q[i];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_FILL:  if (pop_fire && fill_q == LAST_SLOT) state_d = BK_ROUND;
      BK_ROUND: if (rnd_q == LAST_ROUND) state_d = BK_ADD;
      BK_ADD:   if (add_go) state_d = BK_FILL;
      default:  state_d = BK_FILL;
    endcase
  end

  always_comb begin
    pop_ready_o          = (state_q == BK_FILL);
    digest_o.valid       = out_busy_q;
    digest_o.digest_word = digest_q[out_idx_q];
    digest_o.digest_last = (out_idx_q == 3'(DIGEST_WORDS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_FILL;
      fill_q     <= '0;
      rnd_q      <= '0;
      final_q    <= 1'b0;
      out_busy_q <= 1'b0;
      out_idx_q  <= '0;
      chain_q    <= H_INIT;
    end else begin
      state_q <= state_d;
      if (pop_fire) begin
        fill_q <= fill_q + 4'd1;
        if (fill_q == LAST_SLOT) begin
          final_q <= pop_data_i.final_word;
          rnd_q   <= '0;
        end
      end
      if (state_q == BK_ROUND) begin
        rnd_q <= rnd_q + 7'd1;
      end
      if (add_go) begin
        if (final_q) begin
          chain_q    <= H_INIT;
          out_busy_q <= 1'b1;
        end else begin
          chain_q <= chain_sum;
        end
      end
      if (out_fire) begin
        out_idx_q <= out_done ? 3'd0 : out_idx_q + 3'd1;
        if (out_done) out_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_fire) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= pop_data_i.word;
      if (fill_q == LAST_SLOT) wv_q <= chain_q;
    end
    if (state_q == BK_ROUND) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= sched_new;
      wv_q[4]   <= wv_q[3];
      wv_q[3]   <= wv_q[2];
      wv_q[2]   <= {wv_q[1][1:0], wv_q[1][31:2]};
      wv_q[1]   <= wv_q[0];
      wv_q[0]   <= temp;
    end
    if (add_go && final_q) begin
      digest_q <= chain_sum;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sha1_hash_core.sv
// Block flow: the back end fills its window with the sixteen words of a block,
//   runs the eighty rounds and then updates the chain; a message whose padding
//   spills over takes one more block before its first digest beat is offered.
// Throughput is set by the single round unit; the back end pops no word meanwhile.
// Reset (rst_ni, asynchronous, active low) restores the initial chain value,
//   clears the length counter, slot and queue at once.
// ============================================================================
// SHA-1 hash core
// Streaming SHA-1 over big-endian 32-bit message beats with automatic padding
// and a five-beat digest output.
// ============================================================================
`default_nettype none

module sha1_hash_core import sha1_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha1_msg_if.sink      msg_i,
  sha1_digest_if.source digest_o
);

  // The front end accepts message beats, counts the message length and,
  // after the final beat, generates the pad marker, zero words and the two
  // length words. Every word it produces goes into the queue, tagged with a
  // flag on the second length word, the very last word of the padded message.
  q_word_t push_data, pop_data;
  logic    push_valid, push_ready;
  logic    pop_valid, pop_ready;

  sha1_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .msg_i        (msg_i),
    .push_data_o  (push_data),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  // The queue lets the front end take beats while the rounds are running.
  sha1_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_data),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  // The back end gathers sixteen words, runs the eighty rounds one per
  // cycle and folds the result into the chain. When the block closed a
  // message, the chain goes to a digest buffer and is re-initialised, so the
  // next message can be hashed while the digest beats drain.
  sha1_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_data_i  (pop_data),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .digest_o    (digest_o)
  );

endmodule

`default_nettype wire

>>> hdl/sha1_checker.sv
// ============================================================================
// SHA-1 hash core checker
// Port-level assertions on digest framing, ordering and output stability.
// ============================================================================
`default_nettype none

module sha1_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        msg_valid_i,
  input  logic        msg_ready_i,
  input  logic        msg_last_i,
  input  logic        dig_valid_i,
  input  logic        dig_ready_i,
  input  logic [31:0] dig_word_i,
  input  logic        dig_last_i
);

  logic [3:0] pend_q;
  logic [2:0] beat_q;
  logic       msg_end, dig_fire, dig_end;

  assign msg_end  = msg_valid_i && msg_ready_i && msg_last_i;
  assign dig_fire = dig_valid_i && dig_ready_i;
  assign dig_end  = dig_fire && dig_last_i;

  // Messages closed at the input whose digest has not yet fully left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      beat_q <= '0;
    end else begin
      if (msg_end && !dig_end) begin
        pend_q <= pend_q + 4'd1;
      end else if (dig_end && !msg_end) begin
        pend_q <= pend_q - 4'd1;
      end
      if (dig_fire) begin
        beat_q <= dig_last_i ? 3'd0 : beat_q + 3'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_valid_i && !dig_ready_i |=> dig_valid_i && $stable(dig_word_i) && $stable(dig_last_i))
    else $error("digest beat changed while stalled");

  a_last_fifth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_valid_i |-> (dig_last_i == (beat_q == 3'd4)))
    else $error("digest last flag not on the fifth beat");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_valid_i |-> (pend_q != 4'd0))
    else $error("digest beat without a finished message");

  a_gap_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_end |=> !dig_valid_i)
    else $error("next digest started straight after the last beat");

endmodule

bind sha1_hash_core sha1_checker u_sha1_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .msg_valid_i (msg_i.valid),
  .msg_ready_i (msg_i.ready),
  .msg_last_i  (msg_i.last_word),
  .dig_valid_i (digest_o.valid),
  .dig_ready_i (digest_o.ready),
  .dig_word_i  (digest_o.digest_word),
  .dig_last_i  (digest_o.digest_last)
);

`default_nettype wire
